/* hw/rtl/riff_chunk_sparsifier_core_assert.svh */
// ----------------------------------------------------------------------------
// RIFF chunk sparsifier assertion macros
// Shared assertion forms for the checker of the sparsifier core.
// ----------------------------------------------------------------------------
`ifndef RIFF_CHUNK_SPARSIFIER_CORE_ASSERT_SVH
`define RIFF_CHUNK_SPARSIFIER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcs: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcs: next-cycle check failed");

`endif

/* hw/rtl/rcs_pkg.sv */
// ----------------------------------------------------------------------------
// RIFF chunk sparsifier package
// Constants, command word type and helper functions shared by the core.
// ----------------------------------------------------------------------------
package rcs_pkg;

   localparam int DELTA_SPAN   = 16;
   localparam int TAIL_BYTES   = 4096;
   localparam int HIDX_W       = (DELTA_SPAN > 1) ? $clog2(DELTA_SPAN) : 1;
   localparam int TAIL_W       = $clog2(TAIL_BYTES + 1);
   localparam int TAIL_COUNT_W = 13;
   localparam int POS_W        = 48;
   localparam int SUB_W        = 4;

   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_BIT  = 3;
   localparam logic REG_FILE_SIZE = 1'b0;

   localparam logic [2:0] HDR_BYTES_LAST = 3'd7;
   localparam logic [3:0] HDR_TAIL_N = (TAIL_BYTES < 8) ? 4'(TAIL_BYTES) : 4'd8;

   localparam logic [31:0] ID_JUNK = 32'h4B4E554A;
   localparam logic [31:0] ID_LIST = 32'h5453494C;
   localparam logic [31:0] ID_RIFF = 32'h46464952;

   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_TAIL   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_RECORD   = 3'd1,
      OP_DATA     = 3'd2,
      OP_TAIL     = 3'd3,
      OP_HDR_TAIL = 3'd4
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [63:0]               data;
      logic [3:0]                count;
      logic                      fin;
      logic                      fin_err;
      logic [POS_W-1:0]          fin_stop;
      logic [TAIL_COUNT_W-1:0]   fin_tail;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } word_type;

   function automatic logic is_printable(input logic [7:0] c);
      return c inside {[8'h20:8'h7E]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

endpackage

/* hw/rtl/rcs_queue.sv */
// ----------------------------------------------------------------------------
// RIFF chunk sparsifier command queue
// Short FIFO of command words between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module rcs_queue (
   input  logic              clock,
   input  logic              reset,
   input  rcs_pkg::word_type push,
   input  logic              pop,
   output logic              full,
   output rcs_pkg::word_type head
);

   rcs_pkg::cmd_type                mem_ff [rcs_pkg::FIFO_DEPTH];
   logic [rcs_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rcs_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rcs_pkg::FIFO_PTR_W:0]    cnt_ff, cnt_in;
   logic                            push_en, pop_en;

   always_comb begin
      push_en = push.valid && !full;
      pop_en  = pop && (cnt_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == rcs_pkg::FIFO_PTR_W'(rcs_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == rcs_pkg::FIFO_PTR_W'(rcs_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + {{rcs_pkg::FIFO_PTR_W{1'b0}}, push_en}
                      - {{rcs_pkg::FIFO_PTR_W{1'b0}}, pop_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   assign full       = (cnt_ff == (rcs_pkg::FIFO_PTR_W + 1)'(rcs_pkg::FIFO_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

endmodule

/* hw/rtl/rcs_front.sv */
// ----------------------------------------------------------------------------
// RIFF chunk sparsifier parser
// Accepts source bytes, walks the chunk structure and issues command words.
// Also holds the file size register behind the APB-style port.
// ----------------------------------------------------------------------------
module rcs_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [7:0]                      req_data_byte,
   output logic                            req_stall,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rcs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rcs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   input  logic                            q_full,
   output rcs_pkg::word_type               push
);

   typedef enum logic [5:0] {
      PH_HEADER = 6'b000001,
      PH_SKIP   = 6'b000010,
      PH_PASS   = 6'b000100,
      PH_DELTA  = 6'b001000,
      PH_TAIL   = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [rcs_pkg::POS_W-1:0]        fs_ff, fs_in;
   logic [rcs_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [63:0]                      hdr_ff, hdr_in;
   logic [2:0]                       hcnt_ff, hcnt_in;
   logic [32:0]                      rem_ff, rem_in;
   logic [rcs_pkg::POS_W-1:0]        hstart_ff, hstart_in;
   logic [rcs_pkg::POS_W:0]          hend_ff, hend_in;
   logic [rcs_pkg::TAIL_W-1:0]       tail_ff, tail_in;
   logic [rcs_pkg::HIDX_W-1:0]       hidx_ff, hidx_in;
   logic [7:0]                       hist_ff [rcs_pkg::DELTA_SPAN];

   logic                             csr_wr, accept, work, pos_done, hist_clr, hist_we;
   logic [rcs_pkg::POS_W-1:0]        new_pos;
   logic [63:0]                      shift_new;
   logic [31:0]                      id, len;
   logic                             hdr_ok, is_skip, is_form;
   logic [32:0]                      rounded;
   logic [rcs_pkg::TAIL_W-1:0]       tail_next;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[rcs_pkg::CSR_IDX_BIT] == rcs_pkg::REG_FILE_SIZE);
   assign csr_prdata = (csr_paddr[rcs_pkg::CSR_IDX_BIT] == rcs_pkg::REG_FILE_SIZE) ?
                       rcs_pkg::CSR_DATA_W'(fs_ff) : '0;
   assign fs_in      = csr_wr ? csr_pwdata[rcs_pkg::POS_W-1:0] : fs_ff;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign work      = accept && (phase_ff != PH_DONE);

   always_comb begin
      new_pos   = pos_ff + 1'b1;
      pos_done  = (new_pos >= fs_ff);
      shift_new = {req_data_byte, hdr_ff[63:8]};
      id        = shift_new[31:0];
      len       = shift_new[63:32];
      hdr_ok    = rcs_pkg::is_printable(id[7:0])   && rcs_pkg::is_printable(id[15:8]) &&
                  rcs_pkg::is_printable(id[23:16]) && rcs_pkg::is_printable(id[31:24]) &&
                  !(({1'b0, hend_ff} + 50'(len)) > {2'b00, fs_ff});
      is_skip   = (id == rcs_pkg::ID_JUNK) ||
                  (rcs_pkg::is_digit(id[7:0]) && rcs_pkg::is_digit(id[15:8]));
      is_form   = (id == rcs_pkg::ID_LIST) || (id == rcs_pkg::ID_RIFF);
      rounded   = {1'b0, len} + {32'd0, len[0]};
      tail_next = tail_ff + 1'b1;

      phase_in  = phase_ff;
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      hcnt_in   = hcnt_ff;
      rem_in    = rem_ff;
      hstart_in = hstart_ff;
      hend_in   = hend_ff;
      tail_in   = tail_ff;
      hidx_in   = hidx_ff;
      hist_clr  = 1'b0;
      hist_we   = 1'b0;
      push      = '0;
      push.cmd.op = rcs_pkg::OP_NONE;

      if (work) begin
         pos_in = new_pos;
         case (phase_ff)
            PH_HEADER: begin
               if (hcnt_ff == '0) begin
                  hstart_in = pos_ff;
                  hend_in   = {1'b0, pos_ff} + (rcs_pkg::POS_W + 1)'(8);
               end
               hdr_in  = shift_new;
               hcnt_in = hcnt_ff + 1'b1;
               if (hcnt_ff == rcs_pkg::HDR_BYTES_LAST) begin
                  if (!hdr_ok) begin
                     if (!pos_done) begin
                        push.cmd.op    = rcs_pkg::OP_HDR_TAIL;
                        push.cmd.data  = shift_new;
                        push.cmd.count = rcs_pkg::HDR_TAIL_N;
                        tail_in        = rcs_pkg::TAIL_W'(rcs_pkg::HDR_TAIL_N);
                        phase_in       = PH_TAIL;
                        if (int'(rcs_pkg::HDR_TAIL_N) >= rcs_pkg::TAIL_BYTES) begin
                           push.cmd.fin      = 1'b1;
                           push.cmd.fin_err  = 1'b1;
                           push.cmd.fin_stop = hstart_ff;
                           push.cmd.fin_tail =
                              rcs_pkg::TAIL_COUNT_W'(rcs_pkg::HDR_TAIL_N);
                           phase_in          = PH_DONE;
                        end
                     end else begin
                        push.cmd.fin      = 1'b1;
                        push.cmd.fin_stop = hstart_ff;
                        phase_in          = PH_DONE;
                     end
                  end else begin
                     push.cmd.op   = rcs_pkg::OP_RECORD;
                     push.cmd.data = shift_new;
                     if (is_skip) begin
                        rem_in   = rounded;
                        phase_in = (rounded == '0) ? PH_HEADER : PH_SKIP;
                     end else if (is_form) begin
                        rem_in   = 33'd4;
                        phase_in = PH_PASS;
                     end else begin
                        rem_in   = rounded;
                        hist_clr = 1'b1;
                        hidx_in  = '0;
                        phase_in = (rounded == '0) ? PH_HEADER : PH_DELTA;
                     end
                  end
               end
            end
            PH_SKIP: begin
               rem_in = rem_ff - 1'b1;
               if (rem_ff == 33'd1) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_PASS: begin
               push.cmd.op   = rcs_pkg::OP_DATA;
               push.cmd.data = 64'(req_data_byte);
               rem_in        = rem_ff - 1'b1;
               if (rem_ff == 33'd1) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_DELTA: begin
               push.cmd.op   = rcs_pkg::OP_DATA;
               push.cmd.data = 64'(req_data_byte - hist_ff[hidx_ff]);
               hist_we       = 1'b1;
               hidx_in       = (hidx_ff == rcs_pkg::HIDX_W'(rcs_pkg::DELTA_SPAN - 1)) ?
                               '0 : hidx_ff + 1'b1;
               rem_in        = rem_ff - 1'b1;
               if (rem_ff == 33'd1) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_TAIL: begin
               push.cmd.op   = rcs_pkg::OP_TAIL;
               push.cmd.data = 64'(req_data_byte);
               tail_in       = tail_next;
               if ((tail_next >= rcs_pkg::TAIL_W'(rcs_pkg::TAIL_BYTES)) || pos_done) begin
                  push.cmd.fin      = 1'b1;
                  push.cmd.fin_err  = 1'b1;
                  push.cmd.fin_stop = hstart_ff;
                  push.cmd.fin_tail = rcs_pkg::TAIL_COUNT_W'(tail_next);
                  phase_in          = PH_DONE;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         if ((phase_in != PH_DONE) && (phase_in != PH_TAIL) && pos_done) begin
            push.cmd.fin      = 1'b1;
            push.cmd.fin_err  = 1'b0;
            push.cmd.fin_tail = '0;
            push.cmd.fin_stop = ((phase_in == PH_HEADER) && (hcnt_in != '0)) ?
                                hstart_in : new_pos;
            phase_in          = PH_DONE;
         end
         push.valid = (push.cmd.op != rcs_pkg::OP_NONE) || push.cmd.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         fs_ff    <= '0;
         pos_ff   <= '0;
         hcnt_ff  <= '0;
         tail_ff  <= '0;
         hidx_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         fs_ff    <= fs_in;
         pos_ff   <= pos_in;
         hcnt_ff  <= hcnt_in;
         tail_ff  <= tail_in;
         hidx_ff  <= hidx_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff    <= hdr_in;
      rem_ff    <= rem_in;
      hstart_ff <= hstart_in;
      hend_ff   <= hend_in;
      if (hist_clr) begin
         for (int i = 0; i < rcs_pkg::DELTA_SPAN; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (hist_we) begin
         hist_ff[hidx_ff] <= req_data_byte;
      end
   end

endmodule

/* hw/rtl/rcs_back.sv */
// ----------------------------------------------------------------------------
// RIFF chunk sparsifier result sequencer
// Expands queued command words into result words for the registered result
// channel, one per cycle while rsp_stall does not hold a pending word.
// ----------------------------------------------------------------------------
module rcs_back (
   input  logic                               clock,
   input  logic                               reset,
   input  rcs_pkg::word_type                  head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_kind,
   output logic [7:0]                         rsp_out_byte,
   output logic [31:0]                        rsp_chunk_id,
   output logic [31:0]                        rsp_chunk_length,
   output logic [rcs_pkg::POS_W-1:0]          rsp_stop_position,
   output logic                               rsp_had_error,
   output logic [rcs_pkg::TAIL_COUNT_W-1:0]   rsp_tail_count,
   output logic                               rsp_last
);

   logic [rcs_pkg::SUB_W-1:0]               sub_ff, sub_in;
   logic                                    valid_ff, valid_in;
   logic [1:0]                              kind_ff, kind_in;
   logic [7:0]                              byte_ff, byte_in;
   logic [31:0]                             id_ff, id_in;
   logic [31:0]                             len_ff, len_in;
   logic [rcs_pkg::POS_W-1:0]               stop_ff, stop_in;
   logic                                    err_ff, err_in;
   logic [rcs_pkg::TAIL_COUNT_W-1:0]        tc_ff, tc_in;
   logic                                    last_ff, last_in;
   logic [rcs_pkg::SUB_W-1:0]               main_n, total;
   logic                                    load, step;

   always_comb begin
      case (head.cmd.op)
         rcs_pkg::OP_NONE:     main_n = '0;
         rcs_pkg::OP_HDR_TAIL: main_n = head.cmd.count;
         default:              main_n = rcs_pkg::SUB_W'(1);
      endcase
      total   = main_n + {{(rcs_pkg::SUB_W-1){1'b0}}, head.cmd.fin};
      load    = !valid_ff || !rsp_stall;
      step    = head.valid && load;
      last_in = (sub_ff == total - 1'b1);
      pop     = step && last_in;
      sub_in  = sub_ff;
      if (step) begin
         sub_in = last_in ? '0 : sub_ff + 1'b1;
      end
      valid_in = step || (valid_ff && rsp_stall);

      kind_in = rcs_pkg::KIND_STATUS;
      byte_in = '0;
      id_in   = '0;
      len_in  = '0;
      stop_in = '0;
      err_in  = 1'b0;
      tc_in   = '0;
      if (sub_ff < main_n) begin
         case (head.cmd.op)
            rcs_pkg::OP_RECORD: begin
               kind_in = rcs_pkg::KIND_RECORD;
               id_in   = head.cmd.data[31:0];
               len_in  = head.cmd.data[63:32];
            end
            rcs_pkg::OP_DATA: begin
               kind_in = rcs_pkg::KIND_DATA;
               byte_in = head.cmd.data[7:0];
            end
            rcs_pkg::OP_TAIL: begin
               kind_in = rcs_pkg::KIND_TAIL;
               byte_in = head.cmd.data[7:0];
            end
            rcs_pkg::OP_HDR_TAIL: begin
               kind_in = rcs_pkg::KIND_TAIL;
               byte_in = head.cmd.data[{sub_ff[2:0], 3'b000} +: 8];
            end
            default: begin
               kind_in = rcs_pkg::KIND_STATUS;
            end
         endcase
      end else begin
         kind_in = rcs_pkg::KIND_STATUS;
         stop_in = head.cmd.fin_stop;
         err_in  = head.cmd.fin_err;
         tc_in   = head.cmd.fin_tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         id_ff   <= id_in;
         len_ff  <= len_in;
         stop_ff <= stop_in;
         err_ff  <= err_in;
         tc_ff   <= tc_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_chunk_id      = id_ff;
   assign rsp_chunk_length  = len_ff;
   assign rsp_stop_position = stop_ff;
   assign rsp_had_error     = err_ff;
   assign rsp_tail_count    = tc_ff;
   assign rsp_last          = last_ff;

endmodule

/* hw/rtl/riff_chunk_sparsifier_core.sv */
// ----------------------------------------------------------------------------
// RIFF chunk sparsifier core
// Walks a RIFF source one byte per word and emits chunk records, delta-coded
// payload bytes, raw tail bytes and a final status.
//
// The req channel carries one source byte per word; a word is taken at a
// clock edge with req_valid high and req_stall low. The rsp channel carries
// one result word per transfer, with rsp_last on the final result caused by
// a source byte. Program file_size over the csr port while the core is idle.
// A byte is taken every cycle while the command queue has room. Its first
// result is queued and then registered before it shows on rsp_valid. Results
// leave at one per cycle while rsp_stall is low; a bad header gives eight
// results from one byte, so the input may stall while the result sequencer
// works through them. When the receiver holds rsp_stall, the result register
// keeps its word, the four-entry command queue fills, and req_stall rises.
// A synchronous reset clears the walk to header gathering at offset zero,
// sets file_size to zero and empties the queue and the result register.
// ----------------------------------------------------------------------------
module riff_chunk_sparsifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_kind,
   output logic [7:0]                         rsp_out_byte,
   output logic [31:0]                        rsp_chunk_id,
   output logic [31:0]                        rsp_chunk_length,
   output logic [rcs_pkg::POS_W-1:0]          rsp_stop_position,
   output logic                               rsp_had_error,
   output logic [rcs_pkg::TAIL_COUNT_W-1:0]   rsp_tail_count,
   output logic                               rsp_last,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rcs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rcs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rcs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   rcs_pkg::word_type push;
   rcs_pkg::word_type head;
   logic              q_full;
   logic              pop;

   rcs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .q_full        (q_full),
      .push          (push)
   );

   rcs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   rcs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_chunk_id      (rsp_chunk_id),
      .rsp_chunk_length  (rsp_chunk_length),
      .rsp_stop_position (rsp_stop_position),
      .rsp_had_error     (rsp_had_error),
      .rsp_tail_count    (rsp_tail_count),
      .rsp_last          (rsp_last)
   );

endmodule

/* hw/rtl/rcs_checker.sv */
// ----------------------------------------------------------------------------
// RIFF chunk sparsifier port checker
// Watches the result channel of the core and flags malformed result words.
// ----------------------------------------------------------------------------
`include "riff_chunk_sparsifier_core_assert.svh"

module rcs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [1:0]                         rsp_kind,
   input logic [7:0]                         rsp_out_byte,
   input logic [rcs_pkg::POS_W-1:0]          rsp_stop_position,
   input logic                               rsp_had_error,
   input logic [rcs_pkg::TAIL_COUNT_W-1:0]   rsp_tail_count,
   input logic                               rsp_last
);

   `RCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_last))
   `RCS_ASSERT_NOW(a_status_last, clock, reset, rsp_valid && (rsp_kind == rcs_pkg::KIND_STATUS), rsp_last)
   `RCS_ASSERT_NOW(a_status_fields, clock, reset, rsp_valid && (rsp_kind != rcs_pkg::KIND_STATUS), !rsp_had_error && (rsp_stop_position == '0) && (rsp_tail_count == '0))
   `RCS_ASSERT_NOW(a_byte_zero, clock, reset, rsp_valid && ((rsp_kind == rcs_pkg::KIND_RECORD) || (rsp_kind == rcs_pkg::KIND_STATUS)), rsp_out_byte == '0)

endmodule

bind riff_chunk_sparsifier_core rcs_checker u_rcs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_kind          (rsp_kind),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_stop_position (rsp_stop_position),
   .rsp_had_error     (rsp_had_error),
   .rsp_tail_count    (rsp_tail_count),
   .rsp_last          (rsp_last)
);
